[sv/char_image_morphology_cross_core_defines.svh]
// Assertion macros for the cross-shaped morphology core.
// Used by files that hold concurrent checks; they expect clk and rst_n in scope.
`ifndef CHAR_IMAGE_MORPHOLOGY_CROSS_CORE_DEFINES_SVH
`define CHAR_IMAGE_MORPHOLOGY_CROSS_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CIMC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CIMC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/cimc_pkg.sv]
// Shared types and constants for the cross-shaped morphology core.
// No dependencies; imported by the output buffer and the top level.
package cimc_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_BYTE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_BYTE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;

    // Operating modes; the unused code behaves as replace.
    localparam logic [1:0] MODE_REPLACE = 2'd0;
    localparam logic [1:0] MODE_DILATE  = 2'd1;
    localparam logic [1:0] MODE_ERODE   = 2'd2;

    // Widest supported row.
    localparam int MAX_WIDTH_DEF = 63;

    // One result item on its way to the output port.
    typedef struct packed {
        logic       frame_end;
        logic       row_end;
        logic [7:0] pixel;
    } result_t;

endpackage

[sv/char_image_morphology_cross_core.sv]
// Cross-shaped 3x3 binary morphology (replace, dilate, erode) on a byte raster.
// Depends on cimc_pkg, cimc_out_buf and the assertion macro header.
//
// Usage:
//   Pixels enter on s_axis (tdata[7:0] = pixel) in row order, one request per pixel.
//   Results leave on m_axis: tdata[7:0] = pixel, tuser[0] = last of row,
//   tlast = last of frame. Registers are written on the cfg channel (index, data);
//   the user must write them only while the block is idle, since the block itself
//   does not enforce it. cfg_ready is always high. Throughput is one pixel per clock
//   while the output stage has room and no drain runs. An accepted pixel is held in
//   the input register, then passes through the window logic into the output
//   register. Replace mode answers every pixel. Dilate and erode answer pixel
//   (r-1,c) when pixel (r,c) arrives; the last pixel of the frame then drains the
//   final row, one result per clock while the output stage has room, during which
//   the input register takes at most one more pixel and then holds it. The line
//   stores are a two-bank byte memory and a flag memory, each with one write and
//   one registered read per clock; the read for the next column is fetched one pixel ahead.
//   Reset clears the counters and loads the register defaults (replace mode, width
//   and height one); the line stores need no clearing. When m_axis stalls, the
//   output register and its skid register hold two results and the input register
//   one more pixel, after which s_axis_tready falls.
`include "char_image_morphology_cross_core_defines.svh"

module char_image_morphology_cross_core #(
    parameter int MAX_WIDTH = cimc_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cimc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cimc_pkg::CFG_DATA_W-1:0] cfg_data,
    // Pixel input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] pixel_in
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [7:0] pixel_out
    output logic                            m_axis_tlast,   // frame_end
    output logic [0:0]                      m_axis_tuser    // [0] row_end
);
    import cimc_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int BANK   = 2 ** COL_W;
    localparam int ADDR_W = COL_W + 1;

    // Configuration registers.
    logic [1:0]  op_mode_reg;
    logic [7:0]  fg_byte_reg;
    logic [7:0]  new_byte_reg;
    logic [5:0]  frame_width_reg;
    logic [15:0] frame_height_reg;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_pixel_reg;

    // Raster position and drain of the final row.
    logic [COL_W-1:0] col_reg;
    logic [15:0]      row_reg;
    logic             flush_reg;
    logic [COL_W-1:0] fcol_reg;
    logic             fbank_reg;
    logic             fup_reg;

    // Neighborhood window of the delayed row.
    logic [7:0] left_reg;
    logic [7:0] ctr_reg;
    logic [7:0] right_reg;
    logic [7:0] first_px_reg;
    logic       above_reg;

    // Line stores.
    logic [7:0] row_mem [2*BANK];
    logic       above_mem [BANK];

    // Combinational signals.
    logic [5:0]        fw_clip;
    logic [COL_W-1:0]  w_eff;
    logic [15:0]       h_eff;
    logic [COL_W-1:0]  cur_col;
    logic              cur_last;
    logic              last_row;
    logic              morph_mode;
    logic              erode;
    logic              row_nz;
    logic              up_ok;
    logic              has_left;
    logic              has_right;
    logic              has_down;
    logic              fg_left;
    logic              fg_ctr;
    logic              fg_right;
    logic              fg_down;
    logic              any_fg;
    logic              any_bg;
    logic [7:0]        morph_val;
    logic [7:0]        replace_val;
    logic              out_full;
    logic              fire_norm;
    logic              fire_flush;
    logic              fire;
    logic              go_flush;
    logic              out_push;
    result_t           push_item;
    result_t           out_item;
    logic [COL_W-1:0]  col_inc;
    logic [COL_W-1:0]  col_next;
    logic [15:0]       row_next;
    logic              rd_bank;
    logic [COL_W-1:0]  rd_col;
    logic [COL_W-1:0]  ab_col;
    logic [ADDR_W-1:0] row_wr_addr;
    logic [ADDR_W-1:0] row_rd_addr;
    logic              row_byp;
    logic              ab_we;
    logic              ab_byp;
    logic [7:0]        ctr_start;

    // Effective frame size after the special-case clamps.
    always_comb
    begin
        if (frame_width_reg == 6'd0)
        begin
            fw_clip = 6'd1;
        end
        else if (frame_width_reg > 6'(MAX_WIDTH))
        begin
            fw_clip = 6'(MAX_WIDTH);
        end
        else
        begin
            fw_clip = frame_width_reg;
        end
    end

    assign w_eff = COL_W'(fw_clip);
    assign h_eff = (frame_height_reg == 16'd0) ? 16'd1 : frame_height_reg;

    // Position of the pixel being worked on, in the input row or in the drain.
    assign cur_col    = flush_reg ? fcol_reg : col_reg;
    assign cur_last   = ({1'b0, cur_col} + (COL_W + 1)'(1)) >= {1'b0, w_eff};
    assign last_row   = ({1'b0, row_reg} + 17'd1) >= {1'b0, h_eff};
    assign morph_mode = (op_mode_reg == MODE_DILATE) || (op_mode_reg == MODE_ERODE);
    assign erode      = (op_mode_reg == MODE_ERODE);
    assign row_nz     = (row_reg != 16'd0);

    // Which neighbors lie inside the frame.
    assign up_ok     = flush_reg ? fup_reg : (|row_reg[15:1]);
    assign has_left  = (cur_col != '0);
    assign has_right = !cur_last;
    assign has_down  = !flush_reg;

    // Foreground tests against the current foreground code.
    assign fg_left  = (left_reg == fg_byte_reg);
    assign fg_ctr   = (ctr_reg == fg_byte_reg);
    assign fg_right = (right_reg == fg_byte_reg);
    assign fg_down  = (in_pixel_reg == fg_byte_reg);

    assign any_fg = (up_ok && above_reg) || (has_left && fg_left)
                 || (has_right && fg_right) || (has_down && fg_down);
    assign any_bg = (up_ok && !above_reg) || (has_left && !fg_left)
                 || (has_right && !fg_right) || (has_down && !fg_down);

    // Center pixel after erosion or dilation.
    always_comb
    begin
        if (erode)
        begin
            morph_val = (fg_ctr && any_bg) ? new_byte_reg : ctr_reg;
        end
        else
        begin
            morph_val = (!fg_ctr && any_fg) ? fg_byte_reg : ctr_reg;
        end
    end

    assign replace_val = fg_down ? new_byte_reg : in_pixel_reg;

    // Work proceeds when the output stage has room and a pixel is held or the drain runs.
    assign fire_norm  = !flush_reg && in_valid_reg && !out_full;
    assign fire_flush = flush_reg && !out_full;
    assign fire       = fire_norm || fire_flush;
    assign go_flush   = morph_mode && cur_last && last_row;

    assign s_axis_tready = !in_valid_reg || fire_norm;
    assign cfg_ready     = 1'b1;

    // Result item for this cycle.
    always_comb
    begin
        push_item.pixel     = morph_val;
        push_item.row_end   = cur_last;
        push_item.frame_end = flush_reg && cur_last;
        if (!flush_reg && !morph_mode)
        begin
            push_item.pixel     = replace_val;
            push_item.frame_end = cur_last && last_row;
        end
    end

    assign out_push = fire_flush || (fire_norm && (!morph_mode || row_nz));

    // Counter successors for an input pixel.
    assign col_inc  = col_reg + COL_W'(1);
    assign col_next = cur_last ? '0 : col_inc;
    assign row_next = cur_last ? (last_row ? 16'd0 : row_reg + 16'd1) : row_reg;

    // Read addresses for the window of the next pixel to be worked on.
    always_comb
    begin
        priority if (fire_flush && !cur_last)
        begin
            rd_bank = fbank_reg;
            rd_col  = fcol_reg + COL_W'(2);
            ab_col  = fcol_reg + COL_W'(1);
        end
        else if (fire_norm && go_flush)
        begin
            rd_bank = row_reg[0];
            rd_col  = COL_W'(1);
            ab_col  = '0;
        end
        else if (fire_norm)
        begin
            rd_bank = ~row_next[0];
            rd_col  = col_next + COL_W'(1);
            ab_col  = col_next;
        end
        else
        begin
            rd_bank = ~row_reg[0];
            rd_col  = col_inc;
            ab_col  = col_reg;
        end
    end

    assign row_wr_addr = {row_reg[0], col_reg};
    assign row_rd_addr = {rd_bank, rd_col};
    assign row_byp     = fire_norm && (row_rd_addr == row_wr_addr);
    assign ab_we       = fire_norm && row_nz;
    assign ab_byp      = ab_we && (ab_col == col_reg);

    // First pixel of the current row becomes the first center of the delayed row.
    assign ctr_start = (col_reg == '0) ? in_pixel_reg : first_px_reg;

    // Row store: current row written, delayed row read one column ahead.
    always_ff @(posedge clk)
    begin
        if (fire_norm)
        begin
            row_mem[row_wr_addr] <= in_pixel_reg;
        end
        if (fire)
        begin
            right_reg <= row_byp ? in_pixel_reg : row_mem[row_rd_addr];
        end
    end

    // Flags of the row above the delayed row.
    always_ff @(posedge clk)
    begin
        if (ab_we)
        begin
            above_mem[col_reg] <= fg_ctr;
        end
        if (fire)
        begin
            above_reg <= ab_byp ? fg_ctr : above_mem[ab_col];
        end
    end

    // Window shift and input payload.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_pixel_reg <= s_axis_tdata;
        end
        if (fire_norm && (col_reg == '0))
        begin
            first_px_reg <= in_pixel_reg;
        end
        if (fire_norm && cur_last)
        begin
            ctr_reg <= ctr_start;
        end
        else if (fire)
        begin
            left_reg <= ctr_reg;
            ctr_reg  <= right_reg;
        end
    end

    // Configuration, input occupancy and raster position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg      <= MODE_REPLACE;
            fg_byte_reg      <= 8'd0;
            new_byte_reg     <= 8'd0;
            frame_width_reg  <= 6'd1;
            frame_height_reg <= 16'd1;
            in_valid_reg     <= 1'b0;
            col_reg          <= '0;
            row_reg          <= 16'd0;
            flush_reg        <= 1'b0;
            fcol_reg         <= '0;
            fbank_reg        <= 1'b0;
            fup_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_OP_MODE:      op_mode_reg      <= cfg_data[1:0];
                    CFG_FG_BYTE:      fg_byte_reg      <= cfg_data[7:0];
                    CFG_NEW_BYTE:     new_byte_reg     <= cfg_data[7:0];
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[5:0];
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default:          ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire_norm)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire_norm)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                if (go_flush)
                begin
                    flush_reg <= 1'b1;
                    fcol_reg  <= '0;
                    fbank_reg <= row_reg[0];
                    fup_reg   <= row_nz;
                end
            end
            else if (fire_flush)
            begin
                fcol_reg <= fcol_reg + COL_W'(1);
                if (cur_last)
                begin
                    flush_reg <= 1'b0;
                end
            end
        end
    end

    // Output register with skid stage.
    cimc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (push_item),
        .full      (out_full),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (out_item)
    );

    assign m_axis_tdata    = out_item.pixel;
    assign m_axis_tlast    = out_item.frame_end;
    assign m_axis_tuser[0] = out_item.row_end;

    // A frame that ends in a morphology mode starts draining its last row.
    `CIMC_ASSERT_NXT(a_flush_starts, fire_norm && go_flush, flush_reg && (fcol_reg == '0),
        "final row drain did not start at column zero")
    // The drain always begins at the first column.
    `CIMC_ASSERT_IMP(a_flush_col0, $rose(flush_reg), fcol_reg == '0,
        "drain entered with a nonzero column")
    // The output stage is never pushed while its skid entry is occupied.
    `CIMC_ASSERT_IMP(a_no_overflow, out_push, !out_full,
        "result pushed into a full output stage")
    // The last pixel of a frame returns the raster position to the origin.
    `CIMC_ASSERT_NXT(a_frame_wrap, fire_norm && cur_last && last_row,
        (row_reg == 16'd0) && (col_reg == '0), "raster position did not wrap at frame end")

endmodule

[sv/cimc_out_buf.sv]
// Two-entry output stage (main register plus skid register) for result items.
// Depends on cimc_pkg for the result item type.
module cimc_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cimc_pkg::result_t push_data,
    output logic             full,
    output logic             m_valid,
    input  logic             m_ready,
    output cimc_pkg::result_t m_data
);
    import cimc_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_data_reg;
    result_t skid_data_reg;
    logic    pop;

    // The main register drains when the receiver takes its request.
    assign pop     = main_valid_reg && m_ready;
    assign full    = skid_valid_reg;
    assign m_valid = main_valid_reg;
    assign m_data  = main_data_reg;

    // Occupancy of the two entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload moves with the occupancy above.
    always_ff @(posedge clk)
    begin
        if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                main_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule
